FILE: hw/rtl/wft_pkg.sv
// ============================================================================
// Word frequency table package
// Shared types, result codes and default sizes of the word frequency table.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package wft_pkg;

    localparam int TABLE_ENTRIES_DEF = 16;
    localparam int WORD_BYTES_DEF    = 8;
    localparam int COUNT_BITS_DEF    = 16;
    localparam int MAX_RESULTS       = 16;

    localparam logic [15:0] TOTAL_MAX = 16'hFFFF;

    localparam logic ACT_ADD  = 1'b0;
    localparam logic ACT_LIST = 1'b1;

    typedef enum logic [1:0] {
        KIND_ADD   = 2'd0,
        KIND_ENTRY = 2'd1,
        KIND_EMPTY = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        STATUS_NEW  = 2'd0,
        STATUS_HIT  = 2'd1,
        STATUS_FULL = 2'd2
    } status_t;

    typedef struct packed {
        kind_t       kind;
        status_t     status;
        logic [63:0] entry_word;
        logic [15:0] entry_count;
        logic [15:0] total_words;
        logic        last;
    } res_t;

endpackage

`default_nettype wire

FILE: hw/rtl/wft_if.sv
// ============================================================================
// Word frequency table channels
// Valid/ready channels for command beats and result beats.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

interface wft_cmd_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [63:0] word;

    modport source (output valid, output action, output word, input ready);
    modport sink   (input valid, input action, input word, output ready);
endinterface

interface wft_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [1:0]  status;
    logic [63:0] entry_word;
    logic [15:0] entry_count;
    logic [15:0] total_words;
    logic        last;

    modport source (output valid, output kind, output status, output entry_word,
                    output entry_count, output total_words, output last, input ready);
    modport sink   (input valid, input kind, input status, input entry_word,
                    input entry_count, input total_words, input last, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/wft_ram.sv
// ============================================================================
// Generic single-port-write RAM
// One write port and one read port with a registered read.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module wft_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/wft_core.sv
// ============================================================================
// Word frequency table sequencer
// Scans the key and count memories one entry a cycle to count words and to
// select the listing order by repeated minimum passes.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module wft_core #(
    parameter int TABLE_ENTRIES = wft_pkg::TABLE_ENTRIES_DEF,
    parameter int WORD_BYTES    = wft_pkg::WORD_BYTES_DEF,
    parameter int COUNT_BITS    = wft_pkg::COUNT_BITS_DEF,
    localparam int KEY_BITS     = 8 * WORD_BYTES,
    localparam int IDX_BITS     = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cmd_valid,
    output logic                       cmd_ready,
    input  wire logic                  cmd_action,
    input  wire logic [63:0]           cmd_word,
    input  wire logic                  res_free,
    output logic                       res_load,
    output wft_pkg::res_t              res_beat,
    output logic                       mem_rd_en,
    output logic      [IDX_BITS-1:0]   mem_rd_addr,
    output logic                       mem_wr_en,
    output logic      [IDX_BITS-1:0]   mem_wr_addr,
    output logic      [KEY_BITS-1:0]   key_wr_data,
    output logic      [COUNT_BITS-1:0] cnt_wr_data,
    input  wire logic [KEY_BITS-1:0]   key_rd_data,
    input  wire logic [COUNT_BITS-1:0] cnt_rd_data
);

    localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
    localparam int RES_W  = $clog2(wft_pkg::MAX_RESULTS + 1);
    localparam int LW     = (CNT_W > RES_W) ? CNT_W : RES_W;
    localparam int PAIR_W = COUNT_BITS + KEY_BITS;

    typedef enum logic [5:0] {
        S_IDLE       = 6'b000001,
        S_ADD_SCAN   = 6'b000010,
        S_ADD_DONE   = 6'b000100,
        S_LIST_SCAN  = 6'b001000,
        S_LIST_DONE  = 6'b010000,
        S_EMPTY_DONE = 6'b100000
    } state_t;

    state_t                state_reg,    state_next;
    logic [KEY_BITS-1:0]   word_reg,     word_next;
    logic [CNT_W-1:0]      used_reg,     used_next;
    logic [15:0]           total_reg,    total_next;
    logic [CNT_W-1:0]      issue_reg,    issue_next;
    logic                  pend_vld_reg, pend_vld_next;
    logic [IDX_BITS-1:0]   pend_idx_reg, pend_idx_next;
    logic                  hit_reg,      hit_next;
    logic [IDX_BITS-1:0]   hit_idx_reg,  hit_idx_next;
    logic [COUNT_BITS-1:0] hit_cnt_reg,  hit_cnt_next;
    logic                  best_vld_reg, best_vld_next;
    logic [PAIR_W-1:0]     best_reg,     best_next;
    logic                  prev_vld_reg, prev_vld_next;
    logic [PAIR_W-1:0]     prev_reg,     prev_next;
    logic [LW-1:0]         emitted_reg,  emitted_next;

    logic                  issue_more;
    logic [PAIR_W-1:0]     rd_pair;
    logic                  qualify;
    logic                  better;
    logic [15:0]           total_inc;
    logic [COUNT_BITS-1:0] cnt_inc;
    logic [LW-1:0]         emit_cnt;
    logic                  emit_last;
    logic [63:0]           word_out;

    assign issue_more = issue_reg < used_reg;
    assign rd_pair    = {cnt_rd_data, key_rd_data};
    assign qualify    = !prev_vld_reg || (rd_pair > prev_reg);
    assign better     = !best_vld_reg || (rd_pair < best_reg);
    assign total_inc  = (total_reg == wft_pkg::TOTAL_MAX) ? total_reg : total_reg + 16'd1;
    assign cnt_inc    = (hit_cnt_reg == {COUNT_BITS{1'b1}}) ? hit_cnt_reg
                                                            : hit_cnt_reg + COUNT_BITS'(1);
    assign emit_cnt   = emitted_reg + LW'(1);
    assign emit_last  = (emit_cnt == LW'(used_reg)) || (emit_cnt == LW'(wft_pkg::MAX_RESULTS));
    assign word_out   = 64'(word_reg) << (64 - KEY_BITS);

    assign cmd_ready   = (state_reg == S_IDLE);
    assign mem_rd_addr = issue_reg[IDX_BITS-1:0];

    always_comb
    begin
        state_next    = state_reg;
        word_next     = word_reg;
        used_next     = used_reg;
        total_next    = total_reg;
        issue_next    = issue_reg;
        pend_vld_next = pend_vld_reg;
        pend_idx_next = pend_idx_reg;
        hit_next      = hit_reg;
        hit_idx_next  = hit_idx_reg;
        hit_cnt_next  = hit_cnt_reg;
        best_vld_next = best_vld_reg;
        best_next     = best_reg;
        prev_vld_next = prev_vld_reg;
        prev_next     = prev_reg;
        emitted_next  = emitted_reg;

        mem_rd_en   = 1'b0;
        mem_wr_en   = 1'b0;
        mem_wr_addr = hit_idx_reg;
        key_wr_data = word_reg;
        cnt_wr_data = cnt_inc;

        res_load             = 1'b0;
        res_beat.kind        = wft_pkg::KIND_ADD;
        res_beat.status      = wft_pkg::STATUS_NEW;
        res_beat.entry_word  = word_out;
        res_beat.entry_count = 16'd0;
        res_beat.total_words = total_reg;
        res_beat.last        = 1'b1;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    word_next     = cmd_word[63 -: KEY_BITS];
                    issue_next    = '0;
                    pend_vld_next = 1'b0;
                    best_vld_next = 1'b0;
                    prev_vld_next = 1'b0;
                    emitted_next  = '0;
                    if (cmd_action == wft_pkg::ACT_ADD)
                    begin
                        state_next = S_ADD_SCAN;
                    end
                    else if (used_reg == '0)
                    begin
                        state_next = S_EMPTY_DONE;
                    end
                    else
                    begin
                        state_next = S_LIST_SCAN;
                    end
                end
            end

            S_ADD_SCAN:
            begin
                mem_rd_en     = issue_more;
                pend_vld_next = issue_more;
                pend_idx_next = issue_reg[IDX_BITS-1:0];
                if (issue_more)
                begin
                    issue_next = issue_reg + CNT_W'(1);
                end
                if (pend_vld_reg && (key_rd_data == word_reg))
                begin
                    hit_next     = 1'b1;
                    hit_idx_next = pend_idx_reg;
                    hit_cnt_next = cnt_rd_data;
                    state_next   = S_ADD_DONE;
                end
                else if (!pend_vld_reg && !issue_more)
                begin
                    hit_next   = 1'b0;
                    state_next = S_ADD_DONE;
                end
            end

            S_ADD_DONE:
            begin
                if (res_free)
                begin
                    res_load   = 1'b1;
                    state_next = S_IDLE;
                    if (hit_reg)
                    begin
                        mem_wr_en            = 1'b1;
                        total_next           = total_inc;
                        res_beat.status      = wft_pkg::STATUS_HIT;
                        res_beat.entry_count = 16'(cnt_inc);
                        res_beat.total_words = total_inc;
                    end
                    else if (used_reg < CNT_W'(TABLE_ENTRIES))
                    begin
                        mem_wr_en            = 1'b1;
                        mem_wr_addr          = used_reg[IDX_BITS-1:0];
                        cnt_wr_data          = COUNT_BITS'(1);
                        used_next            = used_reg + CNT_W'(1);
                        total_next           = total_inc;
                        res_beat.status      = wft_pkg::STATUS_NEW;
                        res_beat.entry_count = 16'd1;
                        res_beat.total_words = total_inc;
                    end
                    else
                    begin
                        res_beat.status = wft_pkg::STATUS_FULL;
                    end
                end
            end

            S_LIST_SCAN:
            begin
                mem_rd_en     = issue_more;
                pend_vld_next = issue_more;
                if (issue_more)
                begin
                    issue_next = issue_reg + CNT_W'(1);
                end
                if (pend_vld_reg && qualify && better)
                begin
                    best_vld_next = 1'b1;
                    best_next     = rd_pair;
                end
                if (!pend_vld_reg && !issue_more)
                begin
                    state_next = S_LIST_DONE;
                end
            end

            S_LIST_DONE:
            begin
                res_beat.kind        = wft_pkg::KIND_ENTRY;
                res_beat.entry_word  = 64'(best_reg[KEY_BITS-1:0]) << (64 - KEY_BITS);
                res_beat.entry_count = 16'(best_reg[PAIR_W-1 -: COUNT_BITS]);
                res_beat.last        = emit_last;
                if (res_free)
                begin
                    res_load      = 1'b1;
                    prev_vld_next = 1'b1;
                    prev_next     = best_reg;
                    best_vld_next = 1'b0;
                    issue_next    = '0;
                    pend_vld_next = 1'b0;
                    emitted_next  = emit_cnt;
                    state_next    = emit_last ? S_IDLE : S_LIST_SCAN;
                end
            end

            S_EMPTY_DONE:
            begin
                res_beat.kind       = wft_pkg::KIND_EMPTY;
                res_beat.entry_word = 64'd0;
                if (res_free)
                begin
                    res_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            used_reg     <= '0;
            total_reg    <= '0;
            pend_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            used_reg     <= used_next;
            total_reg    <= total_next;
            pend_vld_reg <= pend_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg     <= word_next;
        issue_reg    <= issue_next;
        pend_idx_reg <= pend_idx_next;
        hit_reg      <= hit_next;
        hit_idx_reg  <= hit_idx_next;
        hit_cnt_reg  <= hit_cnt_next;
        best_vld_reg <= best_vld_next;
        best_reg     <= best_next;
        prev_vld_reg <= prev_vld_next;
        prev_reg     <= prev_next;
        emitted_reg  <= emitted_next;
    end

endmodule

`default_nettype wire

FILE: hw/rtl/word_frequency_table_unit.sv
// ============================================================================
// Word frequency table unit
// Counts distinct words in a key memory and a count memory and lists them by
// ascending count, ties by ascending word, through a registered result port.
// ============================================================================
// An add beat has its result registered after a scan of the n stored entries,
// one entry a cycle, that stops at the first match. A list beat gives
// min(n, 16) entry beats, or one empty beat when n is zero, each entry found by
// a full scan. The next command is taken once the last beat is registered.
// Reset clears the entry count, the word total and the control state at once;
// the memories are not cleared and need no clearing.
`timescale 1ns / 1ps
`default_nettype none

module word_frequency_table_unit #(
    parameter int TABLE_ENTRIES = wft_pkg::TABLE_ENTRIES_DEF,
    parameter int WORD_BYTES    = wft_pkg::WORD_BYTES_DEF,
    parameter int COUNT_BITS    = wft_pkg::COUNT_BITS_DEF
) (
    input wire logic   clk,
    input wire logic   rst_n,
    wft_cmd_if.sink    cmd,
    wft_res_if.source  res
);

    localparam int KEY_BITS = 8 * WORD_BYTES;
    localparam int IDX_BITS = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    logic                  res_free;
    logic                  res_load;
    wft_pkg::res_t         res_beat;
    logic                  res_vld_reg;
    wft_pkg::res_t         res_data_reg;
    logic                  mem_rd_en;
    logic [IDX_BITS-1:0]   mem_rd_addr;
    logic                  mem_wr_en;
    logic [IDX_BITS-1:0]   mem_wr_addr;
    logic [KEY_BITS-1:0]   key_wr_data;
    logic [COUNT_BITS-1:0] cnt_wr_data;
    logic [KEY_BITS-1:0]   key_rd_data;
    logic [COUNT_BITS-1:0] cnt_rd_data;

    wft_core #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .WORD_BYTES    (WORD_BYTES),
        .COUNT_BITS    (COUNT_BITS)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd.valid),
        .cmd_ready   (cmd.ready),
        .cmd_action  (cmd.action),
        .cmd_word    (cmd.word),
        .res_free    (res_free),
        .res_load    (res_load),
        .res_beat    (res_beat),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .key_wr_data (key_wr_data),
        .cnt_wr_data (cnt_wr_data),
        .key_rd_data (key_rd_data),
        .cnt_rd_data (cnt_rd_data)
    );

    wft_ram #(
        .WIDTH (KEY_BITS),
        .DEPTH (TABLE_ENTRIES)
    ) u_key_ram (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (key_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (key_rd_data)
    );

    wft_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (TABLE_ENTRIES)
    ) u_cnt_ram (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (cnt_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (cnt_rd_data)
    );

    assign res_free = !res_vld_reg || res.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_vld_reg <= 1'b0;
        end
        else if (res_load)
        begin
            res_vld_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            res_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_data_reg <= res_beat;
        end
    end

    assign res.valid       = res_vld_reg;
    assign res.kind        = res_data_reg.kind;
    assign res.status      = res_data_reg.status;
    assign res.entry_word  = res_data_reg.entry_word;
    assign res.entry_count = res_data_reg.entry_count;
    assign res.total_words = res_data_reg.total_words;
    assign res.last        = res_data_reg.last;

endmodule

`default_nettype wire
